[rtl/core/acsa_pkg.sv]
// Shared types and constants for the ADC channel scan averager.
package acsa_pkg;

	localparam int SLOT_COUNT    = 3;
	localparam int SLOT_W        = 2;
	localparam int SAMPLE_W      = 12;
	localparam int MUX_W         = 4;
	localparam int AVERAGE_SHIFT = 3;
	localparam int RESET_SUM     = 20000;
	localparam int MIN_SUM_W     = 15;
	localparam int MAX_AVERAGE   = 4095;
	localparam int SETTLE_TICKS  = 2;

	typedef logic [1:0] settle_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [MUX_W-1:0] mux_code_t;
	typedef logic [SLOT_COUNT-1:0] ref_map_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SLOT0_MUX = 2'd0,
		REG_SLOT1_MUX = 2'd1,
		REG_SLOT2_MUX = 2'd2,
		REG_REF_MAP   = 2'd3
	} cfg_reg_t;

	localparam slot_t SLOT_LAST = slot_t'(SLOT_COUNT - 1);

	// One result request.
	typedef struct packed {
		logic                start_conversion;
		logic                sample_taken;
		logic                average_valid;
		slot_t               finished_slot;
		logic [SAMPLE_W-1:0] average_value;
		mux_code_t           mux_select;
		logic                reference_select;
	} result_t;

endpackage

[rtl/core/adc_channel_scan_averager_core.sv]
// Top level of the ADC channel scan averager.
//
// Each input request is one scan tick and carries the latest 12-bit result
// read from the converter. The block scans three slots round-robin. After a
// slot switch the first tick's result is thrown away as settling time, the
// following ticks are summed until SAMPLES_PER_AVERAGE results are in, and
// the next tick publishes the sum shifted right by three (saturated to 4095)
// as that slot's average and moves on to the next slot. Every tick yields
// exactly one result request with the conversion strobe, the averaging flags
// and the mux code and reference of the slot selected after the tick.
// Both channels use valid/stall. A request accepted into the input register
// has its result loaded into the output register when that register is free;
// one request per cycle is sustained while the receiver does not stall, since
// the tick logic is a single counter compare, one add and a slot mux between
// the input register and the result register. When the receiver stalls, the
// result holds and the input register still takes one more request before
// stall is raised toward the sender. Reset clears both stages, loads the
// configuration defaults and starts with a switch pending and a sum of 20000,
// so the very first tick publishes 2500 for slot 0.
module adc_channel_scan_averager_core #(
	parameter int SAMPLES_PER_AVERAGE = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  acsa_pkg::cfg_reg_t             cfg_index,
	input  logic [acsa_pkg::MUX_W-1:0]     cfg_data,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [acsa_pkg::SAMPLE_W-1:0]  conversion_result,
	// Output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           start_conversion,
	output logic                           sample_taken,
	output logic                           average_valid,
	output logic [1:0]                     finished_slot,
	output logic [acsa_pkg::SAMPLE_W-1:0]  average_value,
	output logic [acsa_pkg::MUX_W-1:0]     mux_select,
	output logic                           reference_select
);
	import acsa_pkg::*;

	// The sum must hold the reset value and a full block of samples.
	localparam int RAW_SUM_W = $clog2(SAMPLES_PER_AVERAGE * (2 ** SAMPLE_W));
	localparam int SUM_W     = (RAW_SUM_W > MIN_SUM_W) ? RAW_SUM_W : MIN_SUM_W;
	localparam int COUNT_W   = $clog2(SAMPLES_PER_AVERAGE + 1);

	// Configuration registers.
	mux_code_t slot0_mux_q;
	mux_code_t slot1_mux_q;
	mux_code_t slot2_mux_q;
	ref_map_t  ref_map_q;

	// Scan state.
	logic [COUNT_W-1:0] count_q;
	settle_t            settle_q;
	slot_t              slot_q;
	logic [SUM_W-1:0]   sum_q;

	logic [COUNT_W-1:0] count_d;
	settle_t            settle_d;
	slot_t              slot_d;
	logic [SUM_W-1:0]   sum_d;
	result_t            result_d;

	// Input stage and result stage.
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                out_valid_q;
	result_t             result_q;
	logic                out_free;
	logic                advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_mux_q <= mux_code_t'(0);
			slot1_mux_q <= mux_code_t'(1);
			slot2_mux_q <= mux_code_t'(2);
			ref_map_q   <= ref_map_t'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT0_MUX: begin
					slot0_mux_q <= cfg_data;
				end
				REG_SLOT1_MUX: begin
					slot1_mux_q <= cfg_data;
				end
				REG_SLOT2_MUX: begin
					slot2_mux_q <= cfg_data;
				end
				REG_REF_MAP: begin
					ref_map_q <= cfg_data[SLOT_COUNT-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The input register refills whenever it is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= conversion_result;
		end
	end

	acsa_tick #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
		.COUNT_W            (COUNT_W),
		.SUM_W              (SUM_W)
	) u_tick (
		.count_q       (count_q),
		.settle_q      (settle_q),
		.slot_q        (slot_q),
		.sum_q         (sum_q),
		.sample        (sample_s1),
		.slot0_mux_code(slot0_mux_q),
		.slot1_mux_code(slot1_mux_q),
		.slot2_mux_code(slot2_mux_q),
		.reference_map (ref_map_q),
		.count_d       (count_d),
		.settle_d      (settle_d),
		.slot_d        (slot_d),
		.sum_d         (sum_d),
		.result        (result_d)
	);

	// The scan state moves only when a tick leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= COUNT_W'(SAMPLES_PER_AVERAGE);
			settle_q <= '0;
			slot_q   <= '0;
			sum_q    <= SUM_W'(RESET_SUM);
		end else if (advance) begin
			count_q  <= count_d;
			settle_q <= settle_d;
			slot_q   <= slot_d;
			sum_q    <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign start_conversion = result_q.start_conversion;
	assign sample_taken     = result_q.sample_taken;
	assign average_valid    = result_q.average_valid;
	assign finished_slot    = result_q.finished_slot;
	assign average_value    = result_q.average_value;
	assign mux_select       = result_q.mux_select;
	assign reference_select = result_q.reference_select;

endmodule

[rtl/core/acsa_tick.sv]
// Next-state and result logic for one scan tick.
module acsa_tick #(
	parameter int SAMPLES_PER_AVERAGE = 8,
	parameter int COUNT_W             = 4,
	parameter int SUM_W               = 15
) (
	input  logic [COUNT_W-1:0]          count_q,
	input  acsa_pkg::settle_t           settle_q,
	input  acsa_pkg::slot_t             slot_q,
	input  logic [SUM_W-1:0]            sum_q,
	input  logic [acsa_pkg::SAMPLE_W-1:0] sample,
	input  acsa_pkg::mux_code_t         slot0_mux_code,
	input  acsa_pkg::mux_code_t         slot1_mux_code,
	input  acsa_pkg::mux_code_t         slot2_mux_code,
	input  acsa_pkg::ref_map_t          reference_map,
	output logic [COUNT_W-1:0]          count_d,
	output acsa_pkg::settle_t           settle_d,
	output acsa_pkg::slot_t             slot_d,
	output logic [SUM_W-1:0]            sum_d,
	output acsa_pkg::result_t           result
);
	import acsa_pkg::*;

	localparam int AVG_W = SUM_W - AVERAGE_SHIFT;

	logic             switch_tick;
	logic [AVG_W-1:0] shifted;
	logic [SAMPLE_W-1:0] average;
	settle_t          settle_inc;
	slot_t            slot_next;

	assign switch_tick = (count_q >= COUNT_W'(SAMPLES_PER_AVERAGE));
	assign shifted     = sum_q[SUM_W-1:AVERAGE_SHIFT];
	assign average     = (shifted > AVG_W'(MAX_AVERAGE)) ? SAMPLE_W'(MAX_AVERAGE)
	                                                     : shifted[SAMPLE_W-1:0];
	assign settle_inc  = (settle_q < settle_t'(SETTLE_TICKS)) ? settle_q + 2'd1 : settle_q;
	assign slot_next   = (slot_q >= SLOT_LAST) ? '0 : slot_q + 2'd1;

	always_comb begin
		result = '0;
		if (switch_tick) begin
			count_d                = '0;
			settle_d               = '0;
			sum_d                  = '0;
			slot_d                 = slot_next;
			result.average_valid   = 1'b1;
			result.finished_slot   = slot_q;
			result.average_value   = average;
		end else begin
			settle_d                = settle_inc;
			slot_d                  = slot_q;
			result.start_conversion = 1'b1;
			if (settle_inc >= settle_t'(SETTLE_TICKS)) begin
				sum_d               = sum_q + SUM_W'(sample);
				count_d             = count_q + COUNT_W'(1);
				result.sample_taken = 1'b1;
			end else begin
				sum_d   = sum_q;
				count_d = count_q;
			end
		end

		case (slot_d)
			2'd0: begin
				result.mux_select = slot0_mux_code;
			end
			2'd1: begin
				result.mux_select = slot1_mux_code;
			end
			2'd2: begin
				result.mux_select = slot2_mux_code;
			end
			default: begin
				result.mux_select = slot0_mux_code;
			end
		endcase
		result.reference_select = (slot_d <= SLOT_LAST) ? reference_map[slot_d] : 1'b0;
	end

endmodule

[verif/scan_average_checker.sv]
`timescale 1ns / 100ps
// Scoreboard that predicts and checks every result request of the scan averager.
module scan_average_checker #(
	parameter int SAMPLES_PER_AVERAGE = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  acsa_pkg::cfg_reg_t                  cfg_index,
	input  logic [acsa_pkg::MUX_W-1:0]          cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [acsa_pkg::SAMPLE_W-1:0]       conversion_result,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                start_conversion,
	input  logic                                sample_taken,
	input  logic                                average_valid,
	input  logic [1:0]                          finished_slot,
	input  logic [acsa_pkg::SAMPLE_W-1:0]       average_value,
	input  logic [acsa_pkg::MUX_W-1:0]          mux_select,
	input  logic                                reference_select,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  averages_seen
);

	// Shadow copy of the configuration registers.
	acsa_pkg::mux_code_t slot_code [acsa_pkg::SLOT_COUNT];
	acsa_pkg::ref_map_t  ref_bits;

	// Shadow copy of the scan state.
	int                  summed;
	acsa_pkg::settle_t   settle;
	acsa_pkg::slot_t     slot;
	int                  sum;

	acsa_pkg::result_t   expected_q [$];
	int                  mismatches;
	int                  published;
	int                  checked;

	// Advances the scan by one tick and returns the result request it causes.
	function automatic acsa_pkg::result_t scan_tick(input logic [acsa_pkg::SAMPLE_W-1:0] sample);
		acsa_pkg::result_t r;
		int avg;
		r = '0;
		if (summed >= SAMPLES_PER_AVERAGE) begin
			avg = sum >> acsa_pkg::AVERAGE_SHIFT;
			if (avg > acsa_pkg::MAX_AVERAGE)
				avg = acsa_pkg::MAX_AVERAGE;
			r.average_valid = 1'b1;
			r.finished_slot = slot;
			r.average_value = avg[acsa_pkg::SAMPLE_W-1:0];
			summed = 0;
			settle = '0;
			sum = 0;
			slot = (slot == acsa_pkg::SLOT_LAST) ? '0 : slot + 1'b1;
		end else begin
			// The settle count holds once it reaches its limit.
			if (settle < acsa_pkg::SETTLE_TICKS)
				settle = settle + 1'b1;
			if (settle >= acsa_pkg::SETTLE_TICKS) begin
				sum += sample;
				summed++;
				r.sample_taken = 1'b1;
			end
			r.start_conversion = 1'b1;
		end
		r.mux_select = slot_code[slot];
		r.reference_select = ref_bits[slot];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		acsa_pkg::result_t got;
		acsa_pkg::result_t want;
		logic bad;
		if (!arst_n) begin
			slot_code[0] = 4'd0;
			slot_code[1] = 4'd1;
			slot_code[2] = 4'd2;
			ref_bits = 3'd4;
			summed = SAMPLES_PER_AVERAGE;
			settle = '0;
			slot = '0;
			sum = acsa_pkg::RESET_SUM;
			expected_q.delete();
			mismatches = 0;
			published = 0;
			checked = 0;
			fail_count <= 0;
			pending <= 0;
			averages_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					acsa_pkg::REG_SLOT0_MUX: slot_code[0] = cfg_data;
					acsa_pkg::REG_SLOT1_MUX: slot_code[1] = cfg_data;
					acsa_pkg::REG_SLOT2_MUX: slot_code[2] = cfg_data;
					acsa_pkg::REG_REF_MAP:   ref_bits = cfg_data[acsa_pkg::SLOT_COUNT-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(scan_tick(conversion_result));
			if (out_valid && !out_stall) begin
				got.start_conversion = start_conversion;
				got.sample_taken = sample_taken;
				got.average_valid = average_valid;
				got.finished_slot = finished_slot;
				got.average_value = average_value;
				got.mux_select = mux_select;
				got.reference_select = reference_select;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result request with nothing expected at %0t", $realtime);
				end else begin
					want = expected_q.pop_front();
					if (want.average_valid)
						published++;
					bad = (got.start_conversion !== want.start_conversion) ||
						(got.sample_taken !== want.sample_taken) ||
						(got.average_valid !== want.average_valid) ||
						(got.finished_slot !== want.finished_slot) ||
						(got.average_value !== want.average_value) ||
						(got.mux_select !== want.mux_select) ||
						(got.reference_select !== want.reference_select);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: tick %0d expected start=%0b taken=%0b avg_valid=%0b slot=%0d avg=%0d mux=%0d ref=%0b",
								checked, want.start_conversion, want.sample_taken, want.average_valid,
								want.finished_slot, want.average_value, want.mux_select,
								want.reference_select);
							$display("ERROR: tick %0d actual   start=%0b taken=%0b avg_valid=%0b slot=%0d avg=%0d mux=%0d ref=%0b",
								checked, got.start_conversion, got.sample_taken, got.average_valid,
								got.finished_slot, got.average_value, got.mux_select,
								got.reference_select);
						end
					end
					checked++;
				end
			end
			fail_count <= mismatches;
			pending <= expected_q.size();
			averages_seen <= published;
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Top of the scan averager testbench: clock, reset, stimulus and final verdict.
module tb_top;

	localparam int SAMPLES = 8;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	acsa_pkg::cfg_reg_t                 cfg_index = acsa_pkg::REG_SLOT0_MUX;
	logic [acsa_pkg::MUX_W-1:0]         cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic [acsa_pkg::SAMPLE_W-1:0]      conversion_result = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic                               start_conversion;
	logic                               sample_taken;
	logic                               average_valid;
	logic [1:0]                         finished_slot;
	logic [acsa_pkg::SAMPLE_W-1:0]      average_value;
	logic [acsa_pkg::MUX_W-1:0]         mux_select;
	logic                               reference_select;

	// Percentages of cycles in which the sender holds back a request and the
	// receiver stalls; each phase of the run sets its own pattern.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int fail_count;
	int pending;
	int averages_seen;
	int ticks_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	adc_channel_scan_averager_core #(
		.SAMPLES_PER_AVERAGE(SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.conversion_result(conversion_result),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.start_conversion(start_conversion),
		.sample_taken(sample_taken),
		.average_valid(average_valid),
		.finished_slot(finished_slot),
		.average_value(average_value),
		.mux_select(mux_select),
		.reference_select(reference_select)
	);

	scan_average_checker #(
		.SAMPLES_PER_AVERAGE(SAMPLES)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.conversion_result(conversion_result),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.start_conversion(start_conversion),
		.sample_taken(sample_taken),
		.average_valid(average_valid),
		.finished_slot(finished_slot),
		.average_value(average_value),
		.mux_select(mux_select),
		.reference_select(reference_select),
		.fail_count(fail_count),
		.pending(pending),
		.averages_seen(averages_seen)
	);

	// The receiver decides afresh on every edge whether to stall. Valid from
	// the block never depends on this, so a free-running pattern is legal.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Writes all four registers on consecutive edges. The write enable stays
	// high across the whole burst, so it is never lowered and raised in one step.
	task automatic write_settings(input logic [3:0] m0, input logic [3:0] m1,
		input logic [3:0] m2, input logic [3:0] refs);
		cfg_we <= 1'b1;
		cfg_index <= acsa_pkg::REG_SLOT0_MUX;
		cfg_data <= m0;
		@(posedge clk);
		cfg_index <= acsa_pkg::REG_SLOT1_MUX;
		cfg_data <= m1;
		@(posedge clk);
		cfg_index <= acsa_pkg::REG_SLOT2_MUX;
		cfg_data <= m2;
		@(posedge clk);
		cfg_index <= acsa_pkg::REG_REF_MAP;
		cfg_data <= refs;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one tick request and returns at the edge that accepts it. Idle
	// cycles, if any, come before the request is raised.
	task automatic send_tick(input logic [acsa_pkg::SAMPLE_W-1:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		conversion_result <= sample;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	// Waits until every predicted result has come back, then lets the
	// two-stage pipeline settle a little longer before registers change.
	// The first edge lets the scoreboard count the request just accepted.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Converter readings lean toward the rails so that sums of all zeros and
	// all ones show up now and then, while the rest covers every bit.
	function automatic logic [acsa_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return acsa_pkg::SAMPLE_W'($urandom_range(4095));
		endcase
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_tick(pick_sample());
		wait_idle();
	endtask

	initial begin : stimulus
		logic [acsa_pkg::SAMPLE_W-1:0] directed [$];

		// Reset is held low from the start and released once, on an edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Busy sender, sparse receiver.
		send_idle_pct = 21;
		recv_idle_pct = 69;

		// Directed part with reset register values. The first tick after
		// reset is a switch tick that publishes 2500 for slot 0 and ignores
		// its reading. Slot 1 then averages full-scale readings and slot 2
		// all zeros; each block starts with a settling tick whose reading
		// is thrown away, and ends with a switch tick that also ignores it.
		directed.push_back(12'd1234);
		directed.push_back(12'd777);
		repeat (SAMPLES) directed.push_back(12'hFFF);
		directed.push_back(12'hFFF);
		directed.push_back(12'hFFF);
		repeat (SAMPLES) directed.push_back(12'h000);
		directed.push_back(12'h000);
		directed.push_back(12'hFFF);
		directed.push_back(12'hAAA);
		directed.push_back(12'h555);
		directed.push_back(12'hAAA);
		foreach (directed[i])
			send_tick(directed[i]);
		wait_idle();

		// All channel codes and reference bits at their low extreme.
		write_settings(4'd0, 4'd0, 4'd0, 4'd0);
		run_random(500);

		// Sparse sender, busy receiver, and every register at its high
		// extreme. The reference map gets four ones, and its top bit must
		// be dropped since the map is only three bits wide.
		send_idle_pct = 69;
		recv_idle_pct = 21;
		write_settings(4'hF, 4'hF, 4'hF, 4'hF);
		run_random(500);

		// Full rate on both sides with two random settings.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) begin
			write_settings(4'($urandom_range(15)), 4'($urandom_range(15)),
				4'($urandom_range(15)), 4'($urandom_range(15)));
			run_random(250);
		end

		// Anything unexpected arriving late would still be caught here.
		repeat (10) @(posedge clk);

		$display("Summary: %0d scan ticks sent, %0d slot averages published and checked,",
			ticks_sent, averages_seen);
		$display("Summary: five register settings under three stall patterns.");
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin : watchdog
		#2000000;
		$display("ERROR: run did not finish in time");
		$display("Verification failed");
		$finish;
	end

endmodule
